@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the power state governor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define PSG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define PSG_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/psg_pkg.sv @@
// Types, codes and constants shared by the power state governor.
`timescale 1ns / 1ps

package psg_pkg;

    localparam int TIME_WIDTH_DEF = 48;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int PCT_W       = 7;
    localparam int PERIOD_W    = 16;

    localparam logic [PERIOD_W-1:0] RESOURCE_PERIOD_RESET = 16'd1000;
    localparam logic [PERIOD_W-1:0] WINDOW_PERIOD_RESET   = 16'd250;

    // Recovery hysteresis: thresholds above the limit recover at threshold minus offset.
    localparam logic [PCT_W-1:0] RECOVER_LIMIT  = 7'd10;
    localparam logic [PCT_W-1:0] RECOVER_OFFSET = 7'd8;

    // Over-threshold sample counting.
    localparam logic [1:0] OVER_COUNT_MAX   = 2'd3;
    localparam logic [1:0] OVER_COUNT_ENTER = 2'd2;

    typedef enum logic [2:0] {
        ST_ACTIVE   = 3'd0,
        ST_REDUCED  = 3'd1,
        ST_OCCLUDED = 3'd2,
        ST_PAUSED   = 3'd3,
        ST_HEAVY    = 3'd4,
        ST_SLEEPING = 3'd5
    } power_state_t;

    typedef enum logic [2:0] {
        KIND_EVALUATE     = 3'd0,
        KIND_LOCK         = 3'd1,
        KIND_UNLOCK       = 3'd2,
        KIND_POWER_CHANGE = 3'd3,
        KIND_SUSPEND      = 3'd4,
        KIND_RESUME       = 3'd5
    } event_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COVER_EN         = 3'd0,
        CFG_LOAD_EN          = 3'd1,
        CFG_RAM_LIMIT        = 3'd2,
        CFG_VRAM_LIMIT       = 3'd3,
        CFG_RESOURCE_PERIOD  = 3'd4,
        CFG_WINDOW_PERIOD    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic                cover_en;
        logic                load_en;
        logic [PCT_W-1:0]    ram_limit;
        logic [PCT_W-1:0]    vram_limit;
        logic [PERIOD_W-1:0] resource_period;
        logic [PERIOD_W-1:0] window_period;
    } cfg_t;

    typedef struct packed {
        logic         locked;
        logic         res_sleep;
        logic [1:0]   over_count;
        power_state_t held;
    } gov_state_t;

    function automatic logic [PCT_W-1:0] recover_level(input logic [PCT_W-1:0] thr);
        return (thr > RECOVER_LIMIT) ? (thr - RECOVER_OFFSET) : thr;
    endfunction

endpackage

@@ rtl/core/psg_eval.sv @@
// Combinational event evaluator: next governor state and power state result for one event.
`timescale 1ns / 1ps

module psg_eval
    import psg_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  cfg_t                  cfg,
    input  gov_state_t            st,
    input  logic [TIME_WIDTH-1:0] last_res_time,
    input  logic [TIME_WIDTH-1:0] last_win_time,
    input  logic [2:0]            kind,
    input  logic [TIME_WIDTH-1:0] now_ms,
    input  logic [PCT_W-1:0]      ram_load_pct,
    input  logic [PCT_W-1:0]      vram_load_pct,
    input  logic                  fullscreen_active,
    input  logic                  desktop_covered,
    input  logic                  battery_power,
    output gov_state_t            st_next,
    output logic [TIME_WIDTH-1:0] last_res_time_next,
    output logic [TIME_WIDTH-1:0] last_win_time_next,
    output logic                  result_valid,
    output power_state_t          result_state
);

    logic                  res_en;
    logic [TIME_WIDTH-1:0] res_elapsed;
    logic [TIME_WIDTH-1:0] win_elapsed;
    logic                  sample_due;
    logic                  win_due;
    logic                  ram_over;
    logic                  vram_over;
    logic                  ram_ok;
    logic                  vram_ok;
    logic [1:0]            count_inc;
    logic                  samp_sleep;
    logic [1:0]            samp_count;
    power_state_t          window_state;

    assign res_en      = cfg.load_en;
    // Differences wrap naturally at the stamp width.
    assign res_elapsed = now_ms - last_res_time;
    assign win_elapsed = now_ms - last_win_time;
    assign sample_due  = res_en && (res_elapsed >= TIME_WIDTH'(cfg.resource_period));
    assign win_due     = win_elapsed >= TIME_WIDTH'(cfg.window_period);

    assign ram_over  = (cfg.ram_limit != '0) && (ram_load_pct >= cfg.ram_limit);
    assign vram_over = (cfg.vram_limit != '0) && (vram_load_pct >= cfg.vram_limit);
    assign ram_ok    = ram_load_pct <= recover_level(cfg.ram_limit);
    assign vram_ok   = vram_load_pct <= recover_level(cfg.vram_limit);
    assign count_inc = (st.over_count < OVER_COUNT_MAX) ? (st.over_count + 2'd1)
                                                        : st.over_count;

    // Outcome of one resource sample, used only when a sample is due.
    always_comb
    begin
        samp_sleep = st.res_sleep;
        samp_count = st.over_count;
        if (!st.res_sleep)
        begin
            if (ram_over || vram_over)
            begin
                samp_count = count_inc;
                samp_sleep = count_inc >= OVER_COUNT_ENTER;
            end
            else
            begin
                samp_count = '0;
            end
        end
        else if (ram_ok && vram_ok)
        begin
            samp_sleep = 1'b0;
            samp_count = '0;
        end
    end

    // Window and battery priority: fullscreen, then covered desktop if cover is enabled, then battery.
    always_comb
    begin
        if (fullscreen_active)
        begin
            window_state = ST_PAUSED;
        end
        else if (cfg.cover_en && desktop_covered)
        begin
            window_state = ST_OCCLUDED;
        end
        else if (battery_power)
        begin
            window_state = ST_REDUCED;
        end
        else
        begin
            window_state = ST_ACTIVE;
        end
    end

    always_comb
    begin
        st_next            = st;
        last_res_time_next = last_res_time;
        last_win_time_next = last_win_time;
        result_valid       = 1'b0;
        result_state       = ST_ACTIVE;
        case (kind)
            KIND_EVALUATE:
            begin
                result_valid = 1'b1;
                if (st.locked)
                begin
                    result_state = ST_SLEEPING;
                end
                else
                begin
                    if (sample_due)
                    begin
                        last_res_time_next = now_ms;
                        st_next.res_sleep  = samp_sleep;
                        st_next.over_count = samp_count;
                    end
                    if (res_en && st_next.res_sleep)
                    begin
                        st_next.held = ST_HEAVY;
                        result_state = ST_HEAVY;
                    end
                    else if (!win_due)
                    begin
                        result_state = st.held;
                    end
                    else
                    begin
                        last_win_time_next = now_ms;
                        st_next.held       = window_state;
                        result_state       = window_state;
                    end
                end
            end
            KIND_LOCK, KIND_SUSPEND:
            begin
                st_next.locked = 1'b1;
            end
            KIND_UNLOCK, KIND_RESUME:
            begin
                st_next.locked     = 1'b0;
                last_win_time_next = '0;
            end
            KIND_POWER_CHANGE:
            begin
                last_win_time_next = '0;
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule

@@ rtl/core/power_state_governor.sv @@
// Top level of the power state governor: event input, configuration port and result output.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The governor takes one event beat per clock cycle and keeps up that rate
// indefinitely while the result side is not stalled. Every accepted beat is
// captured in an input register and processed from there by a single pass
// of combinational logic; an evaluate request places its power state in the
// output register, which drives out_valid. Lock, unlock, power-change,
// suspend and resume events update internal state and produce no result
// beat, as do the unused kind codes, which change nothing at all. The output
// register is the only buffer on the result side: when it holds a beat that
// is stalled, a further evaluate waits in the input register and in_stall is
// raised, whereas non-evaluate events still drain. Configuration registers
// are written through a separate valid/ready channel that is always ready;
// they should only be changed while no event is in flight. Time stamps are
// compared modulo 2^TIME_WIDTH, and a period register written as zero lets
// every evaluate through its throttle.
module power_state_governor
    import psg_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Event channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             kind,
    input  logic [TIME_WIDTH-1:0]  now_ms,
    input  logic [PCT_W-1:0]       ram_load_pct,
    input  logic [PCT_W-1:0]       vram_load_pct,
    input  logic                   fullscreen_active,
    input  logic                   desktop_covered,
    input  logic                   battery_power,

    // Result channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             power_state,

    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Input register: one captured event beat.
    logic                  in_valid_reg;
    logic [2:0]            kind_reg;
    logic [TIME_WIDTH-1:0] now_ms_reg;
    logic [PCT_W-1:0]      ram_load_reg;
    logic [PCT_W-1:0]      vram_load_reg;
    logic                  fullscreen_reg;
    logic                  covered_reg;
    logic                  battery_reg;

    // Output register.
    logic                  out_valid_reg;
    power_state_t          power_state_reg;

    // Governor state and configuration.
    gov_state_t            gov_reg;
    gov_state_t            gov_next;
    logic [TIME_WIDTH-1:0] last_res_time_reg;
    logic [TIME_WIDTH-1:0] last_res_time_next;
    logic [TIME_WIDTH-1:0] last_win_time_reg;
    logic [TIME_WIDTH-1:0] last_win_time_next;
    cfg_t                  cfg_reg;

    logic                  in_accept;
    logic                  is_eval;
    logic                  out_free;
    logic                  fire;
    logic                  fire_eval;
    logic                  result_valid;
    power_state_t          result_state;

    psg_eval #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_eval (
        .cfg                (cfg_reg),
        .st                 (gov_reg),
        .last_res_time      (last_res_time_reg),
        .last_win_time      (last_win_time_reg),
        .kind               (kind_reg),
        .now_ms             (now_ms_reg),
        .ram_load_pct       (ram_load_reg),
        .vram_load_pct      (vram_load_reg),
        .fullscreen_active  (fullscreen_reg),
        .desktop_covered    (covered_reg),
        .battery_power      (battery_reg),
        .st_next            (gov_next),
        .last_res_time_next (last_res_time_next),
        .last_win_time_next (last_win_time_next),
        .result_valid       (result_valid),
        .result_state       (result_state)
    );

    // The captured beat is processed when it either needs no output slot or
    // the output register is free or being emptied in this cycle.
    assign is_eval   = kind_reg == KIND_EVALUATE;
    assign out_free  = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && (!is_eval || out_free);
    assign fire_eval = fire && is_eval;
    assign in_stall  = in_valid_reg && !fire;
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign power_state = power_state_reg;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg       <= kind;
            now_ms_reg     <= now_ms;
            ram_load_reg   <= ram_load_pct;
            vram_load_reg  <= vram_load_pct;
            fullscreen_reg <= fullscreen_active;
            covered_reg    <= desktop_covered;
            battery_reg    <= battery_power;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && result_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && result_valid)
        begin
            power_state_reg <= result_state;
        end
    end

    // Governor state advances only when an event beat is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gov_reg.locked     <= 1'b0;
            gov_reg.res_sleep  <= 1'b0;
            gov_reg.over_count <= '0;
            gov_reg.held       <= ST_ACTIVE;
            last_res_time_reg  <= '0;
            last_win_time_reg  <= '0;
        end
        else if (fire)
        begin
            gov_reg           <= gov_next;
            last_res_time_reg <= last_res_time_next;
            last_win_time_reg <= last_win_time_next;
        end
    end

    // Configuration registers; writes to indexes beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cover_en        <= 1'b0;
            cfg_reg.load_en         <= 1'b0;
            cfg_reg.ram_limit       <= '0;
            cfg_reg.vram_limit      <= '0;
            cfg_reg.resource_period <= RESOURCE_PERIOD_RESET;
            cfg_reg.window_period   <= WINDOW_PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_COVER_EN:        cfg_reg.cover_en        <= cfg_data[0];
                CFG_LOAD_EN:         cfg_reg.load_en         <= cfg_data[0];
                CFG_RAM_LIMIT:       cfg_reg.ram_limit       <= cfg_data[PCT_W-1:0];
                CFG_VRAM_LIMIT:      cfg_reg.vram_limit      <= cfg_data[PCT_W-1:0];
                CFG_RESOURCE_PERIOD: cfg_reg.resource_period <= cfg_data[PERIOD_W-1:0];
                CFG_WINDOW_PERIOD:   cfg_reg.window_period   <= cfg_data[PERIOD_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // A locked governor answers every evaluate with sleeping.
    `PSG_ASSERT(a_locked_sleeps, fire_eval && gov_reg.locked |=> out_valid && power_state == ST_SLEEPING, "locked evaluate did not answer sleeping")
    // Resource-heavy is only entered on the second consecutive over-threshold sample.
    `PSG_ASSERT(a_heavy_entry, $rose(gov_reg.res_sleep) |-> gov_reg.over_count == OVER_COUNT_ENTER, "resource-heavy entered without two over samples")
    // The counter stops at the entry count in practice.
    `PSG_ASSERT_NEVER(a_count_bound, gov_reg.over_count == OVER_COUNT_MAX, "over count went past the entry count")
    // Events are only held back when a captured beat is waiting.
    `PSG_ASSERT(a_stall_cause, in_stall |-> in_valid_reg && is_eval && out_valid_reg && out_stall, "input stalled without a blocked evaluate")

endmodule
